@@ hw/rtl/dhjtc_pkg.sv @@
// ----------------------------------------------------------------------------
// dhjtc_pkg
// Shared types, fixed-point constants and helpers for the DH transform chain.
// ----------------------------------------------------------------------------
package dhjtc_pkg;

   localparam logic [24:0] HALF_PI_Q24    = 25'd26353589;
   localparam logic [24:0] QUARTER_PI_Q24 = 25'd13176794;
   localparam logic [33:0] CORDIC_K_Q30   = 34'd652032874;
   localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
   localparam int MAT_ENTRIES = 12;
   // floor(2^40 / HALF_PI_Q24): quotient estimate never overshoots, low by at most one
   localparam logic [15:0] HALF_PI_RECIP  = 16'd41721;

   typedef enum logic [1:0] {
      MODE_SET,
      MODE_MUL,
      MODE_INV
   } mac_mode_type;

   // CORDIC arc tangent table, Q2.30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] v;
      unique case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         default: v = 34'sd1 <<< (5'd30 - idx);
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if (v > 44'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -44'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

@@ hw/rtl/dh_joint_transform_chain.sv @@
// ----------------------------------------------------------------------------
// dh_joint_transform_chain
// Denavit-Hartenberg joint transforms and chained frame-to-frame queries.
// ----------------------------------------------------------------------------
// Usage: present an item on the req_ ports with start high while busy is
// low; the item is taken at that clock edge and busy stays high until the
// last result has been driven. A set-joint item (req_action 0) builds the
// joint transform from two CORDIC sine/cosine runs and returns one result.
// A query (req_action 1) returns three results, rows 0..2, rsp_last on row 2.
// Each result is on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall, so every result is taken as it appears.
// A query runs each chained joint through the one shared 32x32 multiplier,
// then drains the pipeline and advances to the next joint; an inverse adds a
// pass on the same multiplier, and the three rows are output last.
// Out-of-range items skip the computation and answer with rsp_error set.
// csr_we writes joint_count; the user must write it only while idle, as the
// block does not enforce it. Reset sets joint_count to 6 and marks every
// stored transform as identity through per-joint valid bits; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module dh_joint_transform_chain
   import dhjtc_pkg::*;
#(
   parameter int MAX_JOINTS   = 8,
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [3:0]         req_joint,
   input  logic signed [31:0] req_angle,
   input  logic signed [31:0] req_offset_d,
   input  logic signed [31:0] req_length_a,
   input  logic signed [31:0] req_twist_alpha,
   input  logic [3:0]         req_from_frame,
   input  logic [3:0]         req_to_frame,
   output logic               rsp_valid,
   output logic [1:0]         rsp_row,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic               rsp_error,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [3:0]         csr_wdata
);

   localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int DEPTH = MAX_JOINTS * MAT_ENTRIES;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RINIT, ST_RED, ST_CINIT, ST_CORD, ST_CDONE,
      ST_PIPE, ST_WRITE, ST_NEXT, ST_INV, ST_OUT, ST_ACK
   } state_type;

   state_type state_ff;
   logic [3:0] jcnt_ff;
   logic [4:0] n_lim;

   logic [3:0]         joint_ff, fa_ff, fb_ff, cur_ff, hi_ff, wcnt_ff;
   logic signed [31:0] ang_ff, d_ff, len_ff, alpha_ff;
   logic               err_ff, sel_ff;

   logic [32:0] rem_ff;
   logic [7:0]  quo_ff;
   logic [2:0]  bit_ff;
   logic        neg_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [1:0]  quad_ff;
   logic [4:0]  step_ff;
   logic signed [31:0] cq_ff, sq_ff, ca_ff, sa_ff;

   mac_mode_type mode_ff;
   logic [1:0] r_ff, c_ff, k_ff;
   logic       iss_done_ff;
   logic       p1_v_ff, p1_mem_ff;
   logic [1:0] p1_r_ff, p1_c_ff, p1_k_ff;
   logic signed [31:0] p1_a_ff, p1_b_ff, rd_data_ff;
   logic       p2_v_ff;
   logic [1:0] p2_r_ff, p2_c_ff, p2_k_ff;
   logic signed [63:0] p2_prod_ff;
   logic signed [43:0] sum_ff;
   logic signed [39:0] pq_ff [3][2];
   logic signed [31:0] acc_ff [3][4];
   logic signed [31:0] tmp_ff [3][4];
   logic [MAX_JOINTS-1:0] vld_ff;
   logic [1:0] orow_ff;

   logic               rsp_valid_ff, rsp_error_ff, rsp_last_ff;
   logic [1:0]         rsp_row_ff;
   logic signed [31:0] rsp_col_ff [4];

   logic signed [31:0] mem [DEPTH];

   // Combinational helpers
   logic signed [33:0] src_ang, t_val;
   logic [32:0]        u_val, q_back;
   logic [31:0]        q_prod;
   logic signed [33:0] r_val;
   logic signed [33:0] xs, ys, cx, cy;
   logic signed [31:0] cval, sval, c_rot, s_rot;
   logic [3:0]         cur_m1, jn_m1;
   logic [JW-1:0]      cur_sel, jn_sel;
   logic [AW-1:0]      raddr, waddr;
   logic signed [31:0] op_a, op_b, wdata;
   logic               op_mem;
   logic [1:0]         kmax;
   logic signed [39:0] rnd;
   logic signed [43:0] sum_in;
   logic               set_bad, qry_bad;

   assign n_lim = ({1'b0, jcnt_ff} > 5'(MAX_JOINTS)) ? 5'(MAX_JOINTS) : {1'b0, jcnt_ff};
   assign set_bad = (req_joint == 4'd0) || ({1'b0, req_joint} > n_lim);
   assign qry_bad = ({1'b0, req_from_frame} > n_lim) || ({1'b0, req_to_frame} > n_lim);

   // Angle reduction: quadrant from a reciprocal estimate and one correction,
   // remainder gives r
   assign src_ang = sel_ff ? 34'(alpha_ff) : 34'(ang_ff);
   assign t_val   = src_ang + 34'(QUARTER_PI_Q24);
   assign u_val   = t_val[33] ? 33'(-t_val + 34'(HALF_PI_Q24) - 34'sd1) : t_val[32:0];
   assign q_prod  = 32'(rem_ff[31:16]) * 32'(HALF_PI_RECIP);
   assign q_back  = 33'(quo_ff) * 33'(HALF_PI_Q24);
   assign r_val   = neg_ff
      ? 34'(HALF_PI_Q24) - 34'sd1 - 34'(rem_ff) - 34'(QUARTER_PI_Q24)
      : 34'(rem_ff) - 34'(QUARTER_PI_Q24);

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign cx = (x_ff + 34'sd32) >>> 6;
   assign cy = (y_ff + 34'sd32) >>> 6;
   assign cval = cx[31:0];
   assign sval = cy[31:0];

   always_comb begin
      unique case (quad_ff)
         2'd0: begin c_rot = cval;  s_rot = sval;  end
         2'd1: begin c_rot = -sval; s_rot = cval;  end
         2'd2: begin c_rot = -cval; s_rot = -sval; end
         default: begin c_rot = sval; s_rot = -cval; end
      endcase
   end

   assign cur_m1  = cur_ff - 4'd1;
   assign jn_m1   = joint_ff - 4'd1;
   assign cur_sel = cur_m1[JW-1:0];
   assign jn_sel  = jn_m1[JW-1:0];
   assign raddr   = AW'(int'(cur_sel) * MAT_ENTRIES + int'(k_ff) * 4 + int'(c_ff));
   assign waddr   = AW'(int'(jn_sel) * MAT_ENTRIES + int'(wcnt_ff));
   assign kmax    = (mode_ff == MODE_SET) ? 2'd1 : 2'd2;

   // Operand selection for the shared multiplier
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_mem = 1'b0;
      unique case (mode_ff)
         MODE_SET: begin
            unique case ({r_ff, k_ff[0]})
               3'b000: begin op_a = sq_ff;  op_b = ca_ff; end
               3'b001: begin op_a = sq_ff;  op_b = sa_ff; end
               3'b010: begin op_a = len_ff; op_b = cq_ff; end
               3'b011: begin op_a = cq_ff;  op_b = ca_ff; end
               3'b100: begin op_a = cq_ff;  op_b = sa_ff; end
               default: begin op_a = len_ff; op_b = sq_ff; end
            endcase
         end
         MODE_MUL: begin
            op_a   = acc_ff[r_ff][k_ff];
            op_mem = vld_ff[cur_sel];
            op_b   = (k_ff == c_ff) ? ONE_Q24 : 32'sd0;
         end
         default: begin
            op_a = acc_ff[k_ff][r_ff];
            op_b = acc_ff[k_ff][3];
         end
      endcase
   end

   assign rnd    = 40'((p2_prod_ff + 64'sd8388608) >>> 24);
   assign sum_in = (p2_k_ff == 2'd0) ? 44'(rnd) : sum_ff + 44'(rnd);

   always_comb begin
      unique case (wcnt_ff)
         4'd0:  wdata = cq_ff;
         4'd1:  wdata = sat32(-44'(pq_ff[0][0]));
         4'd2:  wdata = sat32(44'(pq_ff[0][1]));
         4'd3:  wdata = sat32(44'(pq_ff[1][0]));
         4'd4:  wdata = sq_ff;
         4'd5:  wdata = sat32(44'(pq_ff[1][1]));
         4'd6:  wdata = sat32(-44'(pq_ff[2][0]));
         4'd7:  wdata = sat32(44'(pq_ff[2][1]));
         4'd9:  wdata = sa_ff;
         4'd10: wdata = ca_ff;
         4'd11: wdata = d_ff;
         default: wdata = 32'sd0;
      endcase
   end

   // Transform store
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         jcnt_ff      <= 4'd6;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         iss_done_ff  <= 1'b1;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            jcnt_ff <= csr_wdata;
         end

         // Multiply stage: memory data arrives with the issued tags
         p1_v_ff <= (state_ff == ST_PIPE) && !iss_done_ff;
         p2_v_ff <= p1_v_ff;
         p2_r_ff <= p1_r_ff;
         p2_c_ff <= p1_c_ff;
         p2_k_ff <= p1_k_ff;
         p2_prod_ff <= p1_a_ff * (p1_mem_ff ? rd_data_ff : p1_b_ff);

         // Accumulate stage
         if (p2_v_ff) begin
            sum_ff <= sum_in;
            unique case (mode_ff)
               MODE_SET: pq_ff[p2_r_ff][p2_k_ff[0]] <= rnd;
               MODE_MUL: begin
                  if (p2_k_ff == 2'd2) begin
                     tmp_ff[p2_r_ff][p2_c_ff] <= sat32(sum_in +
                        ((p2_c_ff == 2'd3) ? 44'(acc_ff[p2_r_ff][3]) : 44'sd0));
                  end
               end
               default: begin
                  if (p2_k_ff == 2'd2) begin
                     tmp_ff[p2_r_ff][3] <= sat32(-sum_in);
                  end
               end
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  joint_ff <= req_joint;
                  ang_ff   <= req_angle;
                  d_ff     <= req_offset_d;
                  len_ff   <= req_length_a;
                  alpha_ff <= req_twist_alpha;
                  fa_ff    <= req_from_frame;
                  fb_ff    <= req_to_frame;
                  sel_ff   <= 1'b0;
                  orow_ff  <= 2'd0;
                  if (!req_action) begin
                     err_ff   <= set_bad;
                     state_ff <= set_bad ? ST_ACK : ST_RINIT;
                  end else begin
                     err_ff <= qry_bad;
                     for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 4; j++) begin
                           acc_ff[i][j] <= (i == j) ? ONE_Q24 : 32'sd0;
                        end
                     end
                     if (req_from_frame < req_to_frame) begin
                        cur_ff <= req_from_frame + 4'd1;
                        hi_ff  <= req_to_frame;
                     end else begin
                        cur_ff <= req_to_frame + 4'd1;
                        hi_ff  <= req_from_frame;
                     end
                     mode_ff     <= MODE_MUL;
                     r_ff        <= 2'd0;
                     c_ff        <= 2'd0;
                     k_ff        <= 2'd0;
                     iss_done_ff <= 1'b0;
                     if (qry_bad || req_from_frame == req_to_frame) begin
                        state_ff <= ST_OUT;
                     end else begin
                        state_ff <= ST_PIPE;
                     end
                  end
               end
            end
            ST_RINIT: begin
               rem_ff   <= u_val;
               neg_ff   <= t_val[33];
               quo_ff   <= '0;
               bit_ff   <= 3'd0;
               state_ff <= ST_RED;
            end
            ST_RED: begin
               // estimate, subtract back, then correct by at most one
               unique case (bit_ff)
                  3'd0: quo_ff <= q_prod[31:24];
                  3'd1: rem_ff <= rem_ff - q_back;
                  default: begin
                     if (rem_ff >= 33'(HALF_PI_Q24)) begin
                        rem_ff <= rem_ff - 33'(HALF_PI_Q24);
                        quo_ff <= quo_ff + 8'd1;
                     end
                  end
               endcase
               if (bit_ff == 3'd2) begin
                  state_ff <= ST_CINIT;
               end else begin
                  bit_ff <= bit_ff + 3'd1;
               end
            end
            ST_CINIT: begin
               x_ff     <= CORDIC_K_Q30;
               y_ff     <= '0;
               z_ff     <= r_val <<< 6;
               step_ff  <= '0;
               quad_ff  <= neg_ff ? (~quo_ff[1:0] + 2'd1) : quo_ff[1:0];
               state_ff <= ST_CORD;
            end
            ST_CORD: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - atan_q30(step_ff);
               end else begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + atan_q30(step_ff);
               end
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_CDONE;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_CDONE: begin
               if (!sel_ff) begin
                  cq_ff    <= c_rot;
                  sq_ff    <= s_rot;
                  sel_ff   <= 1'b1;
                  state_ff <= ST_RINIT;
               end else begin
                  ca_ff       <= c_rot;
                  sa_ff       <= s_rot;
                  mode_ff     <= MODE_SET;
                  r_ff        <= 2'd0;
                  c_ff        <= 2'd0;
                  k_ff        <= 2'd0;
                  iss_done_ff <= 1'b0;
                  state_ff    <= ST_PIPE;
               end
            end
            ST_PIPE: begin
               if (!iss_done_ff) begin
                  p1_a_ff   <= op_a;
                  p1_b_ff   <= op_b;
                  p1_mem_ff <= op_mem;
                  p1_r_ff   <= r_ff;
                  p1_c_ff   <= c_ff;
                  p1_k_ff   <= k_ff;
                  if (k_ff == kmax) begin
                     k_ff <= 2'd0;
                     if (c_ff == 2'd3 || mode_ff == MODE_SET) begin
                        c_ff <= (mode_ff == MODE_INV) ? 2'd3 : 2'd0;
                        if (r_ff == 2'd2) begin
                           iss_done_ff <= 1'b1;
                        end else begin
                           r_ff <= r_ff + 2'd1;
                        end
                     end else begin
                        c_ff <= c_ff + 2'd1;
                     end
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else if (!p1_v_ff && !p2_v_ff) begin
                  unique case (mode_ff)
                     MODE_SET: begin
                        wcnt_ff  <= '0;
                        state_ff <= ST_WRITE;
                     end
                     MODE_MUL: state_ff <= ST_NEXT;
                     default: begin
                        acc_ff   <= tmp_ff;
                        state_ff <= ST_OUT;
                     end
                  endcase
               end
            end
            ST_NEXT: begin
               acc_ff <= tmp_ff;
               r_ff   <= 2'd0;
               k_ff   <= 2'd0;
               if (cur_ff == hi_ff) begin
                  state_ff <= (fa_ff < fb_ff) ? ST_INV : ST_OUT;
               end else begin
                  cur_ff      <= cur_ff + 4'd1;
                  c_ff        <= 2'd0;
                  iss_done_ff <= 1'b0;
                  state_ff    <= ST_PIPE;
               end
            end
            ST_INV: begin
               // Rotation part is the transpose; translation runs on the MAC
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     tmp_ff[i][j] <= acc_ff[j][i];
                  end
               end
               mode_ff     <= MODE_INV;
               c_ff        <= 2'd3;
               iss_done_ff <= 1'b0;
               state_ff    <= ST_PIPE;
            end
            ST_WRITE: begin
               if (wcnt_ff == 4'd11) begin
                  vld_ff[jn_sel] <= 1'b1;
                  state_ff       <= ST_ACK;
               end else begin
                  wcnt_ff <= wcnt_ff + 4'd1;
               end
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= orow_ff;
               rsp_error_ff <= err_ff;
               rsp_last_ff  <= (orow_ff == 2'd2);
               for (int j = 0; j < 4; j++) begin
                  rsp_col_ff[j] <= err_ff ? 32'sd0 : acc_ff[orow_ff][j];
               end
               if (orow_ff == 2'd2) begin
                  state_ff <= ST_IDLE;
               end else begin
                  orow_ff <= orow_ff + 2'd1;
               end
            end
            ST_ACK: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= 2'd0;
               rsp_error_ff <= err_ff;
               rsp_last_ff  <= 1'b1;
               for (int j = 0; j < 4; j++) begin
                  rsp_col_ff[j] <= 32'sd0;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col0  = rsp_col_ff[0];
   assign rsp_col1  = rsp_col_ff[1];
   assign rsp_col2  = rsp_col_ff[2];
   assign rsp_col3  = rsp_col_ff[3];
   assign rsp_error = rsp_error_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

@@ tb/tb_dh_joint_transform_chain.sv @@
// ----------------------------------------------------------------------------
// tb_dh_joint_transform_chain
// Self-checking bench for the DH joint transform chain: joint sets, chained
// and inverted frame queries and range errors across several joint counts,
// checked row by row against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_dh_joint_transform_chain
   import dhjtc_pkg::*;
();

   localparam longint HALF_PI  = 26353589;
   localparam longint QUART_PI = 13176794;
   localparam longint GAIN_Q30 = 652032874;
   localparam int     NJ       = 8;
   localparam int     STEPS    = 24;
   localparam bit     ACT_SET  = 1'b0;
   localparam bit     ACT_QRY  = 1'b1;

   typedef int mat12_type [12];

   typedef struct packed {
      logic              action;
      logic [3:0]        joint;
      logic [31:0]       angle, offset_d, length_a, twist_alpha;
      logic [3:0]        from_frame, to_frame;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  row;
      logic [31:0] c0, c1, c2, c3;
      logic        err, last;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = 1'b0;
   logic [3:0]         req_joint = '0;
   logic signed [31:0] req_angle = '0, req_offset_d = '0, req_length_a = '0;
   logic signed [31:0] req_twist_alpha = '0;
   logic [3:0]         req_from_frame = '0, req_to_frame = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_row;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic               rsp_error, rsp_last;
   logic               csr_we = 1'b0;
   logic [3:0]         csr_wdata = '0;

   cmd_type   cmd_q[$];
   row_type   rows_due[$];
   mat12_type joint_mats [NJ];
   logic [3:0] count_reg;
   int     idle_pct = 0;
   int     fails = 0;
   bit     took = 1'b0;

   dh_joint_transform_chain uut (.*);

   always #6 clock = ~clock;

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic int sat(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint arctan(input int i);
      case (i)
         0: return 843314857;  1: return 497837829;  2: return 263043837;
         3: return 133525159;  4: return 67021687;   5: return 33543516;
         6: return 16775851;   7: return 8388437;    8: return 4194283;
         9: return 2097149;
         default: return 64'sd1 <<< (30 - i);
      endcase
   endfunction

   function automatic void sincos(input longint ang, output longint c, output longint s);
      longint t, k, z, x, y, xs, ys, cc, ss;
      t = ang + QUART_PI;
      if (t >= 0) k = t / HALF_PI;
      else k = -((-t + HALF_PI - 1) / HALF_PI);
      x = GAIN_Q30;
      y = 0;
      z = (ang - k * HALF_PI) * 64;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - arctan(i);
         end else begin
            x = x + ys; y = y - xs; z = z + arctan(i);
         end
      end
      cc = (x + 32) >>> 6;
      ss = (y + 32) >>> 6;
      case (k & 3)
         0: begin c = cc;  s = ss;  end
         1: begin c = -ss; s = cc;  end
         2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endfunction

   function automatic mat12_type unit_mat();
      mat12_type m;
      foreach (m[i]) m[i] = 0;
      m[0] = ONE_Q24; m[5] = ONE_Q24; m[10] = ONE_Q24;
      return m;
   endfunction

   function automatic mat12_type chain_mul(input mat12_type a, input mat12_type b);
      mat12_type c;
      longint acc;
      for (int r = 0; r < 3; r++)
         for (int k = 0; k < 4; k++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += qmul(a[r*4+j], b[j*4+k]);
            if (k == 3) acc += a[r*4+3];
            c[r*4+k] = sat(acc);
         end
      return c;
   endfunction

   function automatic mat12_type rigid_inv(input mat12_type m);
      mat12_type o;
      longint acc;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) begin
            o[r*4+k] = m[k*4+r];
            acc += qmul(m[k*4+r], m[k*4+3]);
         end
         o[r*4+3] = sat(-acc);
      end
      return o;
   endfunction

   function automatic int joints_in_use();
      return (count_reg < NJ) ? int'(count_reg) : NJ;
   endfunction

   // Work out the rows that one accepted transfer must produce.
   function automatic void predict_transfer(input cmd_type c);
      longint cq, sq, ca, sa, len;
      mat12_type acc;
      int n, lo, hi;
      row_type e;
      n = joints_in_use();
      e = '0;
      if (c.action == ACT_SET) begin
         e.last = 1'b1;
         if (c.joint < 1 || c.joint > n) begin
            e.err = 1'b1;
         end else begin
            sincos(longint'($signed(c.angle)), cq, sq);
            sincos(longint'($signed(c.twist_alpha)), ca, sa);
            len = $signed(c.length_a);
            acc[0] = sat(cq);              acc[1] = sat(-qmul(sq, ca));
            acc[2] = sat(qmul(sq, sa));    acc[3] = sat(qmul(len, cq));
            acc[4] = sat(sq);              acc[5] = sat(qmul(cq, ca));
            acc[6] = sat(-qmul(cq, sa));   acc[7] = sat(qmul(len, sq));
            acc[8] = 0;                    acc[9] = sat(sa);
            acc[10] = sat(ca);             acc[11] = $signed(c.offset_d);
            joint_mats[c.joint-1] = acc;
         end
         rows_due.insert(rows_due.size(), e);
      end else begin
         if (c.from_frame > n || c.to_frame > n) begin
            foreach (acc[i]) acc[i] = 0;
            e.err = 1'b1;
         end else begin
            acc = unit_mat();
            lo = (c.from_frame < c.to_frame) ? c.from_frame : c.to_frame;
            hi = (c.from_frame < c.to_frame) ? c.to_frame : c.from_frame;
            for (int i = lo + 1; i <= hi; i++) acc = chain_mul(acc, joint_mats[i-1]);
            if (c.from_frame < c.to_frame) acc = rigid_inv(acc);
         end
         for (int r = 0; r < 3; r++) begin
            e.row = r[1:0];
            e.c0 = acc[r*4]; e.c1 = acc[r*4+1]; e.c2 = acc[r*4+2]; e.c3 = acc[r*4+3];
            e.last = (r == 2);
            rows_due.insert(rows_due.size(), e);
         end
      end
   endfunction

   // Monitor: take the transfer, predict, then check the result port.
   always @(posedge clock) begin
      row_type got, want;
      if (reset) begin
         foreach (joint_mats[j]) joint_mats[j] = unit_mat();
         count_reg = 4'd6;
         took = 1'b0;
      end else begin
         if (csr_we) count_reg = csr_wdata;
         if (rsp_valid) begin
            got = '{rsp_row, rsp_col0, rsp_col1, rsp_col2, rsp_col3, rsp_error, rsp_last};
            if (rows_due.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, got);
               fails++;
            end else begin
               want = rows_due.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch row/c0/c1/c2/c3/err/last", $time);
                  $display("   expected %0d %h %h %h %h %b %b", want.row, want.c0,
                           want.c1, want.c2, want.c3, want.err, want.last);
                  $display("   actual   %0d %h %h %h %h %b %b", got.row, got.c0,
                           got.c1, got.c2, got.c3, got.err, got.last);
                  fails++;
               end
            end
         end
         took = start && !busy;
         if (took)
            predict_transfer('{req_action, req_joint, req_angle, req_offset_d,
                               req_length_a, req_twist_alpha, req_from_frame,
                               req_to_frame});
      end
   end

   // Driver: advance to the next pending command once the current one is taken.
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            c = cmd_q.pop_front();
            start <= 1'b1;
            req_action <= c.action;           req_joint <= c.joint;
            req_angle <= c.angle;             req_offset_d <= c.offset_d;
            req_length_a <= c.length_a;       req_twist_alpha <= c.twist_alpha;
            req_from_frame <= c.from_frame;   req_to_frame <= c.to_frame;
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0, 1: return $urandom;
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(32'h1000_0000) - 32'h0800_0000;
      endcase
   endfunction

   function automatic cmd_type set_cmd(input int j, input logic [31:0] q, input logic [31:0] d,
                                       input logic [31:0] a, input logic [31:0] al);
      return '{ACT_SET, j[3:0], q, d, a, al, 4'($urandom), 4'($urandom)};
   endfunction

   function automatic cmd_type query_cmd(input int fa, input int fb);
      return '{ACT_QRY, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
               fa[3:0], fb[3:0]};
   endfunction

   function automatic cmd_type random_cmd(input int n);
      int top;
      top = (n < 1) ? 1 : n;
      if ($urandom_range(99) < 12)   // noise: any joint or frame number
         return $urandom_range(1) ?
            set_cmd($urandom_range(15), rand_word(), rand_word(), rand_word(), rand_word())
            : query_cmd($urandom_range(15), $urandom_range(15));
      if ($urandom_range(99) < 45)
         return set_cmd($urandom_range(1, top), rand_word(), rand_word(), rand_word(),
                        rand_word());
      return query_cmd($urandom_range(n), $urandom_range(n));
   endfunction

   task automatic drain();
      while (cmd_q.size() > 0 || start || busy || rows_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(input logic [3:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int counts [6] = '{8, 1, 15, 0, 6, 8};
      int idles  [6] = '{0, 84, 37, 0, 84, 37};
      int n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, both actions and every error case at the reset count.
      cmd_q.insert(cmd_q.size(), query_cmd(3, 3));
      cmd_q.insert(cmd_q.size(),
                   set_cmd(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      cmd_q.insert(cmd_q.size(),
                   set_cmd(2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
      cmd_q.insert(cmd_q.size(), set_cmd(3, 32'd0, 32'd0, 32'd0, 32'd0));
      cmd_q.insert(cmd_q.size(),
                   set_cmd(4, 32'hffffffff, 32'h01000000, 32'hff000000, 32'h0001921f));
      cmd_q.insert(cmd_q.size(),
                   set_cmd(5, 32'h0323f4bd, 32'h00800000, 32'h02000000, 32'hfcdc0b43));
      cmd_q.insert(cmd_q.size(),
                   set_cmd(6, 32'h00c90fdb, 32'hfff00000, 32'h00400000, 32'h00c90fda));
      cmd_q.insert(cmd_q.size(), set_cmd(0, 32'd1, 32'd1, 32'd1, 32'd1));
      cmd_q.insert(cmd_q.size(), set_cmd(7, 32'd1, 32'd1, 32'd1, 32'd1));
      cmd_q.insert(cmd_q.size(), set_cmd(15, 32'd1, 32'd1, 32'd1, 32'd1));
      cmd_q.insert(cmd_q.size(), query_cmd(6, 0));
      cmd_q.insert(cmd_q.size(), query_cmd(0, 6));
      cmd_q.insert(cmd_q.size(), query_cmd(2, 1));
      cmd_q.insert(cmd_q.size(), query_cmd(1, 4));
      cmd_q.insert(cmd_q.size(), query_cmd(0, 0));
      cmd_q.insert(cmd_q.size(), query_cmd(7, 0));
      cmd_q.insert(cmd_q.size(), query_cmd(0, 15));
      cmd_q.insert(cmd_q.size(), query_cmd(15, 15));
      drain();

      foreach (counts[p]) begin
         write_count(counts[p][3:0]);
         idle_pct = idles[p];
         n = (counts[p] < NJ) ? counts[p] : NJ;
         repeat (50) cmd_q.insert(cmd_q.size(), random_cmd(n));
         drain();
      end

      if (fails == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #30000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
